// ===== hdl/lrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared constants, codes and beat types of the LCD rectangle fill sequencer.
// ----------------------------------------------------------------------------
package lrf_pkg;

   localparam int PANEL_WIDTH  = 320;
   localparam int PANEL_HEIGHT = 240;

   localparam int COORD_W = 16;
   localparam int COLOR_W = 16;
   localparam int BYTE_W  = 8;
   localparam int STEP_W  = 4;
   localparam int X_W     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
   localparam int Y_W     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

   localparam logic FUNC_REQUEST = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   localparam logic [BYTE_W-1:0] CMD_COLUMN_WINDOW = 8'h2A;
   localparam logic [BYTE_W-1:0] CMD_ROW_WINDOW    = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE  = 8'h2C;

   localparam logic [STEP_W-1:0] STEP_COL_CMD    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_XS_HI      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_XS_LO      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_XE_HI      = 4'd3;
   localparam logic [STEP_W-1:0] STEP_XE_LO      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_ROW_CMD    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_YS_HI      = 4'd6;
   localparam logic [STEP_W-1:0] STEP_YS_LO      = 4'd7;
   localparam logic [STEP_W-1:0] STEP_YE_HI      = 4'd8;
   localparam logic [STEP_W-1:0] STEP_YE_LO      = 4'd9;
   localparam logic [STEP_W-1:0] STEP_MEM_CMD    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_COLOUR     = 4'd11;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0] rect_w;
      logic [COORD_W-1:0] rect_h;
      logic [COLOR_W-1:0] fill_color;
   } req_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] spi_byte;
      logic              is_data;
      logic              frame_end;
      logic              fill_done;
   } rsp_beat_type;

   typedef struct packed {
      logic           drop;
      logic [X_W-1:0] x_start;
      logic [X_W-1:0] x_end;
      logic [Y_W-1:0] y_start;
      logic [Y_W-1:0] y_end;
   } window_type;

endpackage

// ===== hdl/lrf_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf channels
// Valid/ready channels for fill request beats and SPI byte beats.
// ----------------------------------------------------------------------------
interface lrf_req_if;
   import lrf_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [COORD_W-1:0] rect_x;
   logic [COORD_W-1:0] rect_y;
   logic [COORD_W-1:0] rect_w;
   logic [COORD_W-1:0] rect_h;
   logic [COLOR_W-1:0] fill_color;

   modport source (output valid, func, rect_x, rect_y, rect_w, rect_h, fill_color,
                   input ready);
   modport sink   (input valid, func, rect_x, rect_y, rect_w, rect_h, fill_color,
                   output ready);
endinterface

interface lrf_rsp_if;
   import lrf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] spi_byte;
   logic              is_data;
   logic              frame_end;
   logic              fill_done;

   modport source (output valid, spi_byte, is_data, frame_end, fill_done, input ready);
   modport sink   (input valid, spi_byte, is_data, frame_end, fill_done, output ready);
endinterface

// ===== hdl/lrf_window_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_window_clip
// Clips a requested rectangle to the panel and flags requests to drop.
// ----------------------------------------------------------------------------
module lrf_window_clip (
   input  lrf_pkg::req_beat_type beat,
   output lrf_pkg::window_type   win
);
   import lrf_pkg::*;

   logic [COORD_W:0] x_sum;
   logic [COORD_W:0] y_sum;
   logic [COORD_W:0] x_last;
   logic [COORD_W:0] y_last;
   logic             x_over;
   logic             y_over;

   assign x_sum  = (COORD_W+1)'(beat.rect_x) + (COORD_W+1)'(beat.rect_w);
   assign y_sum  = (COORD_W+1)'(beat.rect_y) + (COORD_W+1)'(beat.rect_h);
   assign x_last = x_sum - (COORD_W+1)'(1);
   assign y_last = y_sum - (COORD_W+1)'(1);
   assign x_over = x_sum > (COORD_W+1)'(PANEL_WIDTH);
   assign y_over = y_sum > (COORD_W+1)'(PANEL_HEIGHT);

   always_comb begin
      win.drop    = (beat.rect_x >= COORD_W'(PANEL_WIDTH))
                 || (beat.rect_y >= COORD_W'(PANEL_HEIGHT))
                 || (beat.rect_w == '0) || (beat.rect_h == '0);
      win.x_start = X_W'(beat.rect_x);
      win.y_start = Y_W'(beat.rect_y);
      win.x_end   = x_over ? X_W'(PANEL_WIDTH - 1) : X_W'(x_last);
      win.y_end   = y_over ? Y_W'(PANEL_HEIGHT - 1) : Y_W'(y_last);
   end

endmodule

// ===== hdl/lrf_fill_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_fill_engine
// Fill state: window, colour, header step and pixel position; byte selection.
// ----------------------------------------------------------------------------
module lrf_fill_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  lrf_pkg::req_beat_type beat,
   input  lrf_pkg::window_type   win,
   output logic                  busy,
   output lrf_pkg::rsp_beat_type rsp
);
   import lrf_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [X_W-1:0]      xs_ff, xs_in, xe_ff, xe_in, col_ff, col_in;
   logic [Y_W-1:0]      ys_ff, ys_in, ye_ff, ye_in, row_ff, row_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                low_ff, low_in;

   logic [COORD_W-1:0]  xs_wide, xe_wide, ys_wide, ye_wide;
   logic                colour_phase;
   logic                last_pixel;
   logic                finish;

   assign busy         = busy_ff;
   assign colour_phase = (step_ff == STEP_COLOUR);
   assign last_pixel   = (col_ff == xe_ff) && (row_ff == ye_ff);
   assign finish       = go && busy_ff && (beat.func == FUNC_TICK) && colour_phase
                      && low_ff && last_pixel;

   assign xs_wide = COORD_W'(xs_ff);
   assign xe_wide = COORD_W'(xe_ff);
   assign ys_wide = COORD_W'(ys_ff);
   assign ye_wide = COORD_W'(ye_ff);

   always_comb begin
      rsp = '{spi_byte: CMD_MEMORY_WRITE, is_data: 1'b0, frame_end: 1'b1, fill_done: 1'b0};
      if (colour_phase) begin
         rsp.is_data   = 1'b1;
         rsp.spi_byte  = low_ff ? color_ff[BYTE_W-1:0] : color_ff[COLOR_W-1:BYTE_W];
         rsp.frame_end = low_ff && last_pixel;
         rsp.fill_done = low_ff && last_pixel;
      end else begin
         unique case (step_ff)
            STEP_COL_CMD: rsp.spi_byte = CMD_COLUMN_WINDOW;
            STEP_XS_HI: rsp = '{xs_wide[COORD_W-1:BYTE_W], 1'b1, 1'b0, 1'b0};
            STEP_XS_LO: rsp = '{xs_wide[BYTE_W-1:0], 1'b1, 1'b0, 1'b0};
            STEP_XE_HI: rsp = '{xe_wide[COORD_W-1:BYTE_W], 1'b1, 1'b0, 1'b0};
            STEP_XE_LO: rsp = '{xe_wide[BYTE_W-1:0], 1'b1, 1'b1, 1'b0};
            STEP_ROW_CMD: rsp.spi_byte = CMD_ROW_WINDOW;
            STEP_YS_HI: rsp = '{ys_wide[COORD_W-1:BYTE_W], 1'b1, 1'b0, 1'b0};
            STEP_YS_LO: rsp = '{ys_wide[BYTE_W-1:0], 1'b1, 1'b0, 1'b0};
            STEP_YE_HI: rsp = '{ye_wide[COORD_W-1:BYTE_W], 1'b1, 1'b0, 1'b0};
            STEP_YE_LO: rsp = '{ye_wide[BYTE_W-1:0], 1'b1, 1'b1, 1'b0};
            default: rsp.spi_byte = CMD_MEMORY_WRITE;
         endcase
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      xs_in    = xs_ff;
      xe_in    = xe_ff;
      ys_in    = ys_ff;
      ye_in    = ye_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      color_in = color_ff;
      low_in   = low_ff;
      if (go) begin
         if (beat.func == FUNC_REQUEST) begin
            if (!busy_ff && !win.drop) begin
               busy_in  = 1'b1;
               step_in  = STEP_COL_CMD;
               xs_in    = win.x_start;
               xe_in    = win.x_end;
               ys_in    = win.y_start;
               ye_in    = win.y_end;
               col_in   = win.x_start;
               row_in   = win.y_start;
               color_in = beat.fill_color;
               low_in   = 1'b0;
            end
         end else if (busy_ff) begin
            if (!colour_phase) begin
               step_in = step_ff + STEP_W'(1);
            end else if (!low_ff) begin
               low_in = 1'b1;
            end else begin
               low_in = 1'b0;
               if (last_pixel) begin
                  busy_in = 1'b0;
                  step_in = STEP_COL_CMD;
               end else if (col_ff == xe_ff) begin
                  col_in = xs_ff;
                  row_in = row_ff + Y_W'(1);
               end else begin
                  col_in = col_ff + X_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_COL_CMD;
         low_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         low_ff  <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff    <= xs_in;
      xe_ff    <= xe_in;
      ys_ff    <= ys_in;
      ye_ff    <= ye_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      color_ff <= color_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_COLOUR)
      else $error("header step beyond colour phase");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == STEP_COL_CMD) && !low_ff)
      else $error("idle with stale header step or byte phase");

   a_pixel_in_window: assert property (@(posedge clock) disable iff (reset)
      busy_ff && colour_phase |-> (col_ff >= xs_ff) && (col_ff <= xe_ff)
                               && (row_ff >= ys_ff) && (row_ff <= ye_ff))
      else $error("pixel position outside window");

   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      finish |=> !busy_ff)
      else $error("still busy after final colour byte");

endmodule

// ===== hdl/lcd_rect_fill_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer_core
// Clips fill rectangles to the panel and streams window commands and colour bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries beats of two kinds. func = 0 is a fill request (rect_x,
//   rect_y, rect_w, rect_h, fill_color); it is dropped when the block is busy,
//   when it starts off the panel or when it is empty. func = 1 is a tick; each
//   tick while busy yields one SPI byte beat on rsp_if, an idle tick yields none.
//   A fill produces 0x2A with four window bytes, 0x2B with four, 0x2C, then
//   2*w*h colour bytes (clipped w, h), high byte first. is_data, frame_end
//   and fill_done qualify each byte; fill_done marks the last one.
//   A beat lands in the input register, the fill engine handles it from there
//   and its byte is registered in the result register that drives rsp_if.valid.
//   One beat is accepted every cycle unless a tick stalls behind a held byte.
//   While rsp_if.ready is low the result register holds its byte; ticks stall
//   behind it, requests and idle ticks still pass. Synchronous reset empties
//   both registers and leaves the block idle.
// ----------------------------------------------------------------------------
module lcd_rect_fill_sequencer_core (
   input  logic     clock,
   input  logic     reset,
   lrf_req_if.sink  req_if,
   lrf_rsp_if.source rsp_if
);
   import lrf_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff, in_beat_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   window_type   win;
   rsp_beat_type eng_rsp;
   logic         busy;
   logic         produces;
   logic         out_free;
   logic         go;

   assign produces = (in_beat_ff.func == FUNC_TICK) && busy;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign go       = in_valid_ff && (!produces || out_free);

   assign req_if.ready = !in_valid_ff || go;

   assign in_beat_in = '{func: req_if.func, rect_x: req_if.rect_x, rect_y: req_if.rect_y,
                         rect_w: req_if.rect_w, rect_h: req_if.rect_h,
                         fill_color: req_if.fill_color};

   always_comb begin
      in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (go && produces) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = eng_rsp;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lrf_window_clip u_clip (
      .beat (in_beat_ff),
      .win  (win)
   );

   lrf_fill_engine u_engine (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .beat  (in_beat_ff),
      .win   (win),
      .busy  (busy),
      .rsp   (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_beat_ff <= in_beat_in;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.spi_byte  = rsp_beat_ff.spi_byte;
   assign rsp_if.is_data   = rsp_beat_ff.is_data;
   assign rsp_if.frame_end = rsp_beat_ff.frame_end;
   assign rsp_if.fill_done = rsp_beat_ff.fill_done;

endmodule

// ===== verif/tb_lcd_rect_fill_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_rect_fill_sequencer_core
// Drives fill requests and ticks into the rectangle fill sequencer. Each SPI
// byte beat is checked against a cycle-free model of the clipping, window
// header and colour stream. Random gaps and stalls on both channels, a long
// receiver hold-off and a full drain are applied along the way.
// ----------------------------------------------------------------------------
module tb_lcd_rect_fill_sequencer_core;
   import lrf_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_TICKS    = 550;
   localparam int MAX_PRINTED     = 40;

   class fill_byte_scoreboard;
      bit                busy;
      logic [STEP_W-1:0] step;
      logic [X_W-1:0]    win_xs, win_xe, column;
      logic [Y_W-1:0]    win_ys, win_ye, row;
      logic [COLOR_W-1:0] colour;
      bit                low_next;
      rsp_beat_type      expected_bytes[$];
      int                errors;
      int                checked;

      function void push_byte(logic [BYTE_W-1:0] b, logic d, logic fe, logic done);
         rsp_beat_type e;
         e.spi_byte  = b;
         e.is_data   = d;
         e.frame_end = fe;
         e.fill_done = done;
         expected_bytes.push_back(e);
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void note_beat(req_beat_type b);
         int x, y, w, h;
         if (b.func == FUNC_REQUEST) begin
            x = b.rect_x;
            y = b.rect_y;
            w = b.rect_w;
            h = b.rect_h;
            if (busy || x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
            if (x + w > PANEL_WIDTH) w = PANEL_WIDTH - x;
            if (y + h > PANEL_HEIGHT) h = PANEL_HEIGHT - y;
            if (w == 0 || h == 0) return;
            win_xs   = X_W'(x);
            win_xe   = X_W'(x + w - 1);
            win_ys   = Y_W'(y);
            win_ye   = Y_W'(y + h - 1);
            column   = X_W'(x);
            row      = Y_W'(y);
            colour   = b.fill_color;
            low_next = 1'b0;
            step     = STEP_COL_CMD;
            busy     = 1'b1;
            return;
         end
         if (!busy) return;
         if (step < STEP_COLOUR) begin
            case (step)
               STEP_COL_CMD: push_byte(CMD_COLUMN_WINDOW, 1'b0, 1'b1, 1'b0);
               STEP_XS_HI:   push_byte(BYTE_W'(win_xs >> 8), 1'b1, 1'b0, 1'b0);
               STEP_XS_LO:   push_byte(BYTE_W'(win_xs), 1'b1, 1'b0, 1'b0);
               STEP_XE_HI:   push_byte(BYTE_W'(win_xe >> 8), 1'b1, 1'b0, 1'b0);
               STEP_XE_LO:   push_byte(BYTE_W'(win_xe), 1'b1, 1'b1, 1'b0);
               STEP_ROW_CMD: push_byte(CMD_ROW_WINDOW, 1'b0, 1'b1, 1'b0);
               STEP_YS_HI:   push_byte(BYTE_W'(win_ys >> 8), 1'b1, 1'b0, 1'b0);
               STEP_YS_LO:   push_byte(BYTE_W'(win_ys), 1'b1, 1'b0, 1'b0);
               STEP_YE_HI:   push_byte(BYTE_W'(win_ye >> 8), 1'b1, 1'b0, 1'b0);
               STEP_YE_LO:   push_byte(BYTE_W'(win_ye), 1'b1, 1'b1, 1'b0);
               default:      push_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
            endcase
            step = step + 1'b1;
         end else if (!low_next) begin
            push_byte(colour[15:8], 1'b1, 1'b0, 1'b0);
            low_next = 1'b1;
         end else begin
            low_next = 1'b0;
            if (column == win_xe && row == win_ye) begin
               push_byte(colour[7:0], 1'b1, 1'b1, 1'b1);
               busy = 1'b0;
               step = STEP_COL_CMD;
            end else begin
               push_byte(colour[7:0], 1'b1, 1'b0, 1'b0);
               if (column == win_xe) begin
                  column = win_xs;
                  row    = row + 1'b1;
               end else begin
                  column = column + 1'b1;
               end
            end
         end
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_byte(input rsp_beat_type got);
         rsp_beat_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h", got.spi_byte));
            return;
         end
         want = expected_bytes.pop_front();
         checked++;
         if (got.spi_byte !== want.spi_byte)
            report($sformatf("byte %0d spi_byte %02h want %02h", checked, got.spi_byte,
                             want.spi_byte));
         if (got.is_data !== want.is_data)
            report($sformatf("byte %0d is_data %b want %b", checked, got.is_data,
                             want.is_data));
         if (got.frame_end !== want.frame_end)
            report($sformatf("byte %0d frame_end %b want %b", checked, got.frame_end,
                             want.frame_end));
         if (got.fill_done !== want.fill_done)
            report($sformatf("byte %0d fill_done %b want %b", checked, got.fill_done,
                             want.fill_done));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   lrf_req_if req_ch ();
   lrf_rsp_if rsp_ch ();

   lcd_rect_fill_sequencer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   fill_byte_scoreboard sb;
   bit gaps_on;
   bit stalls_on;
   int hold_off_cycles;
   int busy_ticks;
   int quiet_cycles;
   bit hold_done;
   bit pause_done;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, long hold-off on request
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.spi_byte  = rsp_ch.spi_byte;
            got.is_data   = rsp_ch.is_data;
            got.frame_end = rsp_ch.frame_end;
            got.fill_done = rsp_ch.fill_done;
            sb.check_byte(got);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] timeout, %0d bytes outstanding", $time, sb.pending());
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic req_beat_type make_beat(logic f, logic [15:0] x, logic [15:0] y,
                                              logic [15:0] w, logic [15:0] h,
                                              logic [15:0] c);
      req_beat_type b;
      b.func       = f;
      b.rect_x     = x;
      b.rect_y     = y;
      b.rect_w     = w;
      b.rect_h     = h;
      b.fill_color = c;
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.func       <= b.func;
      req_ch.rect_x     <= b.rect_x;
      req_ch.rect_y     <= b.rect_y;
      req_ch.rect_w     <= b.rect_w;
      req_ch.rect_h     <= b.rect_h;
      req_ch.fill_color <= b.fill_color;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      if (b.func == FUNC_TICK && sb.busy) busy_ticks++;
      sb.note_beat(b);
   endtask

   task automatic send_request(input int x, input int y, input int w, input int h,
                               input int c);
      send_beat(make_beat(FUNC_REQUEST, 16'(x), 16'(y), 16'(w), 16'(h), 16'(c)));
   endtask

   task automatic send_tick();
      send_beat(make_beat(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom)));
   endtask

   task automatic finish_fill();
      while (sb.busy) send_tick();
   endtask

   // drop valid, then hold until every byte has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_random_fills(input int goal);
      int pick;
      bit quiet;
      while (busy_ticks < goal) begin
         if (!hold_done && sb.busy && busy_ticks >= goal / 3) begin
            hold_off_cycles = HOLD_OFF_CYCLES;
            hold_done       = 1'b1;
         end
         if (!pause_done && busy_ticks >= (2 * goal) / 3) begin
            wait_for_drain();
            pause_done = 1'b1;
         end
         if (sb.busy) begin
            if ($urandom_range(0, 19) == 0)
               send_beat(make_beat(FUNC_REQUEST, 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), 16'($urandom)));
            else
               send_tick();
         end else begin
            quiet     = (busy_ticks >= goal - 120);
            gaps_on   = !quiet && ($urandom_range(0, 2) != 0);
            stalls_on = !quiet && ($urandom_range(0, 2) != 0);
            pick      = $urandom_range(0, 19);
            if (pick < 2)
               send_tick();
            else if (pick == 2)
               send_request($urandom_range(PANEL_WIDTH, 65535), $urandom, $urandom,
                            $urandom, $urandom);
            else if (pick == 3)
               send_request($urandom_range(0, PANEL_WIDTH - 1),
                            $urandom_range(PANEL_HEIGHT, 65535), $urandom, $urandom,
                            $urandom);
            else if (pick < 6)
               send_request(PANEL_WIDTH - $urandom_range(1, 4),
                            PANEL_HEIGHT - $urandom_range(1, 4), $urandom, $urandom,
                            $urandom);
            else if (pick == 6)
               send_request($urandom_range(0, PANEL_WIDTH - 1),
                            $urandom_range(0, PANEL_HEIGHT - 1), $urandom_range(0, 40),
                            $urandom_range(0, 4), $urandom);
            else
               send_request($urandom_range(0, PANEL_WIDTH - 1),
                            $urandom_range(0, PANEL_HEIGHT - 1), $urandom_range(1, 4),
                            $urandom_range(1, 3), $urandom);
         end
      end
      finish_fill();
   endtask

   initial begin
      sb                = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_REQUEST;
      req_ch.rect_x     = '0;
      req_ch.rect_y     = '0;
      req_ch.rect_w     = '0;
      req_ch.rect_h     = '0;
      req_ch.fill_color = '0;
      gaps_on           = 1'b1;
      stalls_on         = 1'b1;
      hold_off_cycles   = 0;
      busy_ticks        = 0;
      quiet_cycles      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_tick();
      send_request(PANEL_WIDTH, 0, 1, 1, 'h1234);
      send_request(0, PANEL_HEIGHT, 1, 1, 'h1234);
      send_request('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
      send_request(10, 10, 0, 5, 'h00FF);
      send_request(10, 10, 5, 0, 'hFF00);
      send_request(0, 0, 1, 1, 'hFFFF);
      finish_fill();
      send_request(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 'hFFFF, 'hFFFF, 'h0000);
      send_tick();
      send_tick();
      send_request(0, 0, 5, 5, 'h5A5A);
      finish_fill();
      send_request(PANEL_WIDTH - 20, 100, 'hFFFF, 1, 'hA5C3);
      finish_fill();
      send_request(200, PANEL_HEIGHT - 20, 1, 'hFFFF, 'h3C96);
      finish_fill();
      send_request(254, 5, 4, 2, 'h8001);
      finish_fill();
      send_request(PANEL_WIDTH - 3, PANEL_HEIGHT - 3, 'h8000, 'h8000, 'h7FFE);
      finish_fill();
      send_tick();
      wait_for_drain();

      busy_ticks = 0;
      run_random_fills(RANDOM_TICKS);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d bytes never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
